// ===== src/bpfa_pkg.sv =====
// Package for the bitmap page frame allocator: sizes, command codes, queue entry type.
// No dependencies.
package bpfa_pkg;
  localparam int NUM_PAGES = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_W = 64;
  localparam int NUM_WORDS = NUM_PAGES / WORD_W;
  localparam int WIDX_W = $clog2(NUM_WORDS);
  localparam int BIT_W = $clog2(WORD_W);
  localparam int PAGE_W = $clog2(NUM_PAGES) + 1;
  localparam int ADDR_W = 48;
  localparam int CNT_W = 13;
  localparam int FRAME_W = ADDR_W - PAGE_SHIFT + 1;

  typedef enum logic [1:0] {
    CMD_MARK_USABLE = 2'd0,
    CMD_ALLOC       = 2'd1,
    CMD_FREE        = 2'd2,
    CMD_RESET_MAP   = 2'd3
  } cmd_t;

  // Classified request: page range [first, last) already clipped to the map.
  typedef struct packed {
    cmd_t             cmd;
    logic [PAGE_W-1:0] first;
    logic [PAGE_W-1:0] last;
    logic [CNT_W-1:0]  count;
    logic [PAGE_W-1:0] limit;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_WRITE, ST_RESULT
  } state_t;
endpackage

// ===== src/bpfa_if.sv =====
// Valid/ready channel interface carrying a payload.
// Depends on nothing; width set per instance.
interface bpfa_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/bpfa_front.sv =====
// Front end: accepts requests, turns byte ranges into clipped page ranges.
// Depends on bpfa_pkg.
module bpfa_front
  import bpfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        cmd,
  input  logic [ADDR_W-1:0] address,
  input  logic [CNT_W-1:0]  page_count,
  input  logic [ADDR_W-1:0] region_length,
  input  logic [CNT_W-1:0]  page_limit,
  output logic              job_valid,
  input  logic              job_ready,
  output job_t              job
);
  // Two-entry queue
  job_t       q [2];
  logic       wp, rp;
  logic [1:0] fill;
  job_t       cls;
  logic [FRAME_W-1:0] f0, f1;

  function automatic logic [PAGE_W-1:0] clip(input logic [FRAME_W-1:0] v);
    return (v > FRAME_W'(NUM_PAGES)) ? PAGE_W'(NUM_PAGES) : v[PAGE_W-1:0];
  endfunction

  always_comb begin
    cls.cmd = cmd_t'(cmd);
    cls.count = page_count;
    cls.limit = (page_limit > CNT_W'(NUM_PAGES)) ? PAGE_W'(NUM_PAGES)
                                                 : PAGE_W'(page_limit);
    f0 = FRAME_W'(address >> PAGE_SHIFT);
    if (cmd == CMD_MARK_USABLE) begin
      f1 = FRAME_W'(({1'b0, address} + {1'b0, region_length}) >> PAGE_SHIFT);
    end else begin
      f1 = f0 + FRAME_W'(page_count);
    end
    cls.first = clip(f0);
    cls.last = clip(f1);
  end

  assign in_ready = (fill != 2'd2);
  assign job_valid = (fill != 2'd0);
  assign job = q[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q[wp] <= cls;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (job_valid && job_ready) rp <= ~rp;
      fill <= fill + 2'((in_valid && in_ready) ? 1 : 0)
                   - 2'((job_valid && job_ready) ? 1 : 0);
    end
  end
endmodule

// ===== src/bpfa_back.sv =====
// Back end: bitmap memory of 64-bit words, first-fit scan and range writes.
// Depends on bpfa_pkg.
module bpfa_back
  import bpfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  job_t              job,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [ADDR_W-1:0] res_address,
  output logic              res_ok
);
  logic [WORD_W-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] set_all; // words forced to all ones since reset or reset_map
  state_t state, state_next;
  job_t   cur;
  logic [WIDX_W:0]   widx;     // word counter, one extra bit for end
  logic [BIT_W-1:0]  bit_i;    // bit within word in scan
  logic [WORD_W-1:0] rword;
  logic              rvalid;
  logic [PAGE_W-1:0] run, start, run_start;
  logic [PAGE_W-1:0] wlo;
  logic [WORD_W-1:0] wmask;
  logic              wval;
  logic [PAGE_W-1:0] pg;
  logic [WORD_W-1:0] rd;
  logic              free_bit, hit, past_end, alloc_bad;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;

  // Scan reads a word, then walks it one page a cycle.
  always_ff @(posedge clk) begin
    rd <= mem[widx[WIDX_W-1:0]];
    if (mem_we) mem[widx[WIDX_W-1:0]] <= mem_wdata;
  end

  always_comb begin
    rword = set_all[widx[WIDX_W-1:0]] ? '1 : rd;
    pg = {widx, bit_i};
    wlo = {widx, {BIT_W{1'b0}}};
    for (int b = 0; b < WORD_W; b++) begin
      wmask[b] = ((wlo + PAGE_W'(b)) >= cur.first) && ((wlo + PAGE_W'(b)) < cur.last);
    end
    free_bit = !rword[bit_i];
    hit = free_bit && (run + 1'b1 == PAGE_W'(cur.count));
    past_end = (pg >= cur.limit);
    run_start = (run == '0) ? pg : start;
    alloc_bad = (job.count == '0) || (PAGE_W'(job.count) > job.limit);
    mem_we = (state == ST_WRITE) && rvalid;
    mem_wdata = (wmask & {WORD_W{wval}}) | (~wmask & rword);
  end

  assign job_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (job_valid) begin
        if (job.cmd == CMD_RESET_MAP) state_next = ST_RESULT;
        else if (job.cmd == CMD_ALLOC) state_next = alloc_bad ? ST_RESULT : ST_SCAN;
        else state_next = ST_WRITE;
      end
      ST_SCAN: if (rvalid) begin
        if (past_end) state_next = ST_RESULT;
        else if (hit) state_next = ST_WRITE;
      end
      ST_WRITE: if (rvalid && widx == (WIDX_W+1)'(NUM_WORDS - 1)) state_next = ST_RESULT;
      ST_RESULT: if (res_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      res_valid <= (state_next == ST_RESULT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_all <= '1;
      rvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          widx <= '0; bit_i <= '0; run <= '0; rvalid <= 1'b0;
          if (job_valid) begin
            cur <= job;
            res_ok <= !(job.cmd == CMD_ALLOC && alloc_bad);
            res_address <= '0;
            wval <= (job.cmd == CMD_ALLOC);
            if (job.cmd == CMD_RESET_MAP) set_all <= '1;
          end
        end
        ST_SCAN: begin
          if (!rvalid) begin
            rvalid <= 1'b1; // read data now valid for widx
          end else if (past_end) begin
            res_ok <= 1'b0;
          end else if (hit) begin
            cur.first <= run_start;
            cur.last <= run_start + PAGE_W'(cur.count);
            res_address <= ADDR_W'(run_start) << PAGE_SHIFT;
            widx <= '0;
            rvalid <= 1'b0;
          end else begin
            run <= free_bit ? run + 1'b1 : '0;
            if (free_bit && run == '0) start <= pg;
            // advance to the next word after its last bit
            if (bit_i == BIT_W'(WORD_W - 1)) begin
              widx <= widx + 1'b1;
              rvalid <= 1'b0;
            end
            bit_i <= bit_i + 1'b1;
          end
        end
        ST_WRITE: begin
          // read-modify-write each word: read it, then write it back through the mask
          rvalid <= !rvalid;
          if (rvalid) begin
            set_all[widx[WIDX_W-1:0]] <= 1'b0;
            widx <= widx + 1'b1;
          end
        end
        ST_RESULT: begin
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// ===== src/bitmap_page_frame_allocator_unit.sv =====
// Bitmap first-fit page allocator: a front end that classifies requests and
// a bitmap back end of 64-bit words, one page examined per scan cycle.
// mark_usable and free rewrite every word of the map; alloc first scans a
// page at a time with a read per word, then rewrites the map the same way;
// reset_map only sets the whole map. The back end holds one request at a time
// while a two-entry queue keeps the input open.
// Depends on bpfa_pkg, bpfa_if, bpfa_front, bpfa_back.
module bitmap_page_frame_allocator_unit
  import bpfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bpfa_if.sink        in_ch,
  bpfa_if.source      out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [CNT_W-1:0] page_limit;
  logic job_valid, job_ready;
  job_t job;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(page_limit) : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) page_limit <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) page_limit <= pwdata[CNT_W-1:0];
  end

  bpfa_front u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .cmd(in_ch.data[1:0]),
    .address(in_ch.data[2 +: ADDR_W]),
    .page_count(in_ch.data[2+ADDR_W +: CNT_W]),
    .region_length(in_ch.data[2+ADDR_W+CNT_W +: ADDR_W]),
    .page_limit,
    .job_valid, .job_ready, .job
  );

  bpfa_back u_back (
    .clk, .rst,
    .job_valid, .job_ready, .job,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .res_address(out_ch.data[ADDR_W-1:0]),
    .res_ok(out_ch.data[ADDR_W])
  );

  a_ready: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ready |=> !job_ready) else $error("back end took two requests");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.data[ADDR_W] |-> out_ch.data[ADDR_W-1:0] == '0)
    else $error("failed alloc with address");
endmodule
